/* rtl/rational_arithmetic_unit_core_defines.svh */
// assertion helpers for the rational arithmetic unit
// every assertion samples on the rising clock and is off during reset
`ifndef RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_CORE_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define RAU_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// antecedent implies consequent in the next cycle
`define RAU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* rtl/rau_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_pkg
// shared widths, operation codes, states and control structs of the
// rational arithmetic unit
// ----------------------------------------------------------------------------
package rau_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int FIELD_WIDTH   = 16;
   localparam int CMD_WIDTH     = 3;
   localparam int NUM_WIDTH     = 33;
   localparam int DEN_WIDTH     = 32;

   // operation codes: fraction ops are reduced, integer ops are not
   typedef enum logic [CMD_WIDTH-1:0] {
      OP_FADD = 3'd0,
      OP_FSUB = 3'd1,
      OP_FMUL = 3'd2,
      OP_FDIV = 3'd3,
      OP_IADD = 3'd4,
      OP_ISUB = 3'd5,
      OP_IMUL = 3'd6,
      OP_IDIV = 3'd7
   } rau_op_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_COMB,
      ST_GCD,
      ST_DIV,
      ST_FIN
   } rau_state_type;

   // which product register the shared multiplier fills
   typedef enum logic [1:0] {
      MSEL_P0,
      MSEL_P1,
      MSEL_P2
   } rau_msel_type;

   typedef struct packed {
      logic         load;
      logic         mul_en;
      rau_msel_type mul_sel;
      logic         combine;
      logic         gcd_step;
      logic         div_init;
      logic         div_step;
      logic         finish;
   } rau_cmd_type;

   typedef struct packed {
      logic reduce;
      logic gcd_done;
      logic gcd_zero;
      logic div_done;
   } rau_sts_type;

endpackage

/* rtl/rau_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_div
// two-lane restoring divider, one quotient bit per cycle in each lane while step is high,
// both lanes share the divisor
// ----------------------------------------------------------------------------
module rau_div #(
   parameter int VALUE_WIDTH = 33
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   init,
   input  logic                   step,
   input  logic [VALUE_WIDTH-1:0] dividend_a,
   input  logic [VALUE_WIDTH-1:0] dividend_b,
   input  logic [VALUE_WIDTH-1:0] divisor,
   output logic [VALUE_WIDTH-1:0] quo_a,
   output logic [VALUE_WIDTH-1:0] quo_b,
   output logic                   done
);

   localparam int CW = $clog2(VALUE_WIDTH + 1);

   logic [VALUE_WIDTH-1:0] dsr_ff;
   logic [VALUE_WIDTH-1:0] qa_ff, qa_in, qb_ff, qb_in;
   logic [VALUE_WIDTH-1:0] ra_ff, ra_in, rb_ff, rb_in;
   logic [CW-1:0]          cnt_ff, cnt_in;
   logic [VALUE_WIDTH:0]   ta, tb;

   // one shift-and-subtract step per lane
   always_comb begin
      ta = {ra_ff, qa_ff[VALUE_WIDTH-1]};
      tb = {rb_ff, qb_ff[VALUE_WIDTH-1]};
      qa_in = qa_ff;
      qb_in = qb_ff;
      ra_in = ra_ff;
      rb_in = rb_ff;
      cnt_in = cnt_ff;
      if (init) begin
         qa_in = dividend_a;
         qb_in = dividend_b;
         ra_in = '0;
         rb_in = '0;
         cnt_in = CW'(VALUE_WIDTH);
      end else if (step && cnt_ff != '0) begin
         if (ta >= {1'b0, dsr_ff}) begin
            ra_in = VALUE_WIDTH'(ta - {1'b0, dsr_ff});
            qa_in = {qa_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            ra_in = ta[VALUE_WIDTH-1:0];
            qa_in = {qa_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         if (tb >= {1'b0, dsr_ff}) begin
            rb_in = VALUE_WIDTH'(tb - {1'b0, dsr_ff});
            qb_in = {qb_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rb_in = tb[VALUE_WIDTH-1:0];
            qb_in = {qb_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 1'b1;
      end
   end

   // step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   // lane registers
   always_ff @(posedge clock) begin
      if (init) begin
         dsr_ff <= divisor;
      end
      qa_ff <= qa_in;
      qb_ff <= qb_in;
      ra_ff <= ra_in;
      rb_ff <= rb_in;
   end

   assign quo_a = qa_ff;
   assign quo_b = qb_ff;
   assign done  = (cnt_ff == '0);

endmodule

/* rtl/rau_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_dp
// datapath: operand registers, shared multiplier, combine, binary gcd,
// exact division by the gcd and the result registers
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_defines.svh"

module rau_dp #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  rau_pkg::rau_cmd_type                   dp_cmd,
   output rau_pkg::rau_sts_type                   dp_sts,
   input  logic [rau_pkg::CMD_WIDTH-1:0]          req_cmd,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_den,
   output logic                                   rsp_valid,
   output logic signed [rau_pkg::NUM_WIDTH-1:0]   rsp_res_num,
   output logic signed [rau_pkg::DEN_WIDTH-1:0]   rsp_res_den,
   output logic                                   rsp_is_proper,
   output logic                                   rsp_zero_gcd_error
);

   localparam int W  = OPERAND_WIDTH;
   localparam int PW = 2 * W;
   localparam int NW = (2 * W + 1 > 64) ? 64 : 2 * W + 1;
   localparam int KW = $clog2(NW + 1);

   rau_pkg::rau_op_type op_ff;
   logic signed [W-1:0]  an_ff, ad_ff, bn_ff, bd_ff;
   logic signed [W-1:0]  ma, mb;
   logic signed [PW-1:0] mprod;
   logic signed [PW-1:0] p0_ff, p1_ff, p2_ff;
   logic signed [NW-1:0] n_c, d_c, n_ff, d_ff;
   logic [NW-1:0]        nm_c, dm_c, nm_ff, dm_ff;
   logic                 nneg_ff, dneg_ff;
   logic [NW-1:0]        gx_ff, gx_in, gy_ff, gy_in, g_c;
   logic [KW-1:0]        gk_ff, gk_in;
   logic [NW-1:0]        qn, qd;
   logic                 div_done;
   logic                 reduce;
   logic [63:0]          n64, d64;
   logic                 prop_c, err_c;
   logic                 rsp_valid_ff;
   logic signed [rau_pkg::NUM_WIDTH-1:0] res_num_ff;
   logic signed [rau_pkg::DEN_WIDTH-1:0] res_den_ff;
   logic                 proper_ff, err_ff;

   // operand capture, narrowed to the operand width
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         op_ff <= rau_pkg::rau_op_type'(req_cmd);
         an_ff <= W'(req_a_num);
         ad_ff <= W'(req_a_den);
         bn_ff <= W'(req_b_num);
         bd_ff <= W'(req_b_den);
      end
   end

   assign reduce = (op_ff == rau_pkg::OP_FADD) || (op_ff == rau_pkg::OP_FSUB) ||
                   (op_ff == rau_pkg::OP_FMUL) || (op_ff == rau_pkg::OP_FDIV);

   // shared multiplier operand selection
   always_comb begin
      case (dp_cmd.mul_sel)
         rau_pkg::MSEL_P0: begin
            ma = an_ff;
            mb = (op_ff == rau_pkg::OP_FMUL || op_ff == rau_pkg::OP_IMUL) ? bn_ff : bd_ff;
         end
         rau_pkg::MSEL_P1: begin
            ma = bn_ff;
            mb = ad_ff;
         end
         rau_pkg::MSEL_P2: begin
            ma = ad_ff;
            mb = (op_ff == rau_pkg::OP_FDIV || op_ff == rau_pkg::OP_IDIV) ? bn_ff : bd_ff;
         end
         default: begin
            ma = an_ff;
            mb = bd_ff;
         end
      endcase
      mprod = PW'(ma) * PW'(mb);
   end

   // product registers
   always_ff @(posedge clock) begin
      if (dp_cmd.mul_en) begin
         case (dp_cmd.mul_sel)
            rau_pkg::MSEL_P0: p0_ff <= mprod;
            rau_pkg::MSEL_P1: p1_ff <= mprod;
            rau_pkg::MSEL_P2: p2_ff <= mprod;
            default:          p0_ff <= mprod;
         endcase
      end
   end

   // combine products into numerator and denominator
   always_comb begin
      case (op_ff)
         rau_pkg::OP_FADD: begin
            n_c = NW'(p0_ff) + NW'(p1_ff);
            d_c = NW'(p2_ff);
         end
         rau_pkg::OP_FSUB: begin
            n_c = NW'(p0_ff) - NW'(p1_ff);
            d_c = NW'(p2_ff);
         end
         rau_pkg::OP_FMUL, rau_pkg::OP_FDIV: begin
            n_c = NW'(p0_ff);
            d_c = NW'(p2_ff);
         end
         rau_pkg::OP_IADD: begin
            n_c = NW'(an_ff) + NW'(p1_ff);
            d_c = NW'(ad_ff);
         end
         rau_pkg::OP_ISUB: begin
            n_c = NW'(an_ff) - NW'(p1_ff);
            d_c = NW'(ad_ff);
         end
         rau_pkg::OP_IMUL: begin
            n_c = NW'(p0_ff);
            d_c = NW'(ad_ff);
         end
         rau_pkg::OP_IDIV: begin
            n_c = NW'(an_ff);
            d_c = NW'(p2_ff);
         end
         default: begin
            n_c = '0;
            d_c = '0;
         end
      endcase
      nm_c = n_c[NW-1] ? NW'(-n_c) : NW'(n_c);
      dm_c = d_c[NW-1] ? NW'(-d_c) : NW'(d_c);
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.combine) begin
         n_ff    <= n_c;
         d_ff    <= d_c;
         nm_ff   <= nm_c;
         dm_ff   <= dm_c;
         nneg_ff <= n_c[NW-1];
         dneg_ff <= d_c[NW-1];
      end
   end

   // binary gcd, one halving or subtract-and-halve per cycle while gcd_step is high
   always_comb begin
      gx_in = gx_ff;
      gy_in = gy_ff;
      gk_in = gk_ff;
      if (dp_cmd.combine) begin
         gx_in = nm_c;
         gy_in = dm_c;
         gk_in = '0;
      end else if (dp_cmd.gcd_step) begin
         if (!gx_ff[0] && !gy_ff[0]) begin
            gx_in = gx_ff >> 1;
            gy_in = gy_ff >> 1;
            gk_in = gk_ff + 1'b1;
         end else if (!gx_ff[0]) begin
            gx_in = gx_ff >> 1;
         end else if (!gy_ff[0]) begin
            gy_in = gy_ff >> 1;
         end else if (gx_ff >= gy_ff) begin
            gx_in = (gx_ff - gy_ff) >> 1;
         end else begin
            gy_in = (gy_ff - gx_ff) >> 1;
         end
      end
   end

   always_ff @(posedge clock) begin
      gx_ff <= gx_in;
      gy_ff <= gy_in;
      gk_ff <= gk_in;
   end

   // one of the two is zero once done, so the or gives the odd part
   assign g_c = (gx_ff | gy_ff) << gk_ff;

   rau_div #(
      .VALUE_WIDTH(NW)
   ) u_div (
      .clock      (clock),
      .reset      (reset),
      .init       (dp_cmd.div_init),
      .step       (dp_cmd.div_step),
      .dividend_a (nm_ff),
      .dividend_b (dm_ff),
      .divisor    (g_c),
      .quo_a      (qn),
      .quo_b      (qd),
      .done       (div_done)
   );

   always_comb begin
      dp_sts.reduce   = reduce;
      dp_sts.gcd_done = (gx_ff == '0) || (gy_ff == '0);
      dp_sts.gcd_zero = (g_c == '0);
      dp_sts.div_done = div_done;
   end

   // result formatting
   always_comb begin
      if (reduce) begin
         if (g_c == '0) begin
            n64    = '0;
            d64    = '0;
            prop_c = 1'b0;
            err_c  = 1'b1;
         end else begin
            n64    = (nneg_ff ^ dneg_ff) ? -64'(qn) : 64'(qn);
            d64    = 64'(qd);
            prop_c = (qn < qd);
            err_c  = 1'b0;
         end
      end else begin
         n64    = 64'(n_ff);
         d64    = 64'(d_ff);
         prop_c = (nm_ff < dm_ff);
         err_c  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.finish) begin
         res_num_ff <= n64[rau_pkg::NUM_WIDTH-1:0];
         res_den_ff <= d64[rau_pkg::DEN_WIDTH-1:0];
         proper_ff  <= prop_c;
         err_ff     <= err_c;
      end
   end

   // result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dp_cmd.finish;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_res_num        = res_num_ff;
   assign rsp_res_den        = res_den_ff;
   assign rsp_is_proper      = proper_ff;
   assign rsp_zero_gcd_error = err_ff;

   `RAU_ASSERT_NEXT(a_strobe_single, rsp_valid_ff, !rsp_valid_ff, "result strobe longer than one cycle")
   `RAU_ASSERT_IMP(a_err_zero, rsp_valid_ff && err_ff, res_num_ff == '0 && res_den_ff == '0 && !proper_ff, "error result is not 0/0")

endmodule

/* rtl/rau_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rau_ctrl
// controller: sequences multiply, combine, gcd and division steps
// ----------------------------------------------------------------------------
`include "rational_arithmetic_unit_core_defines.svh"

module rau_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   output rau_pkg::rau_cmd_type dp_cmd,
   input  rau_pkg::rau_sts_type dp_sts
);

   rau_pkg::rau_state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= rau_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      dp_cmd   = '0;
      dp_cmd.mul_sel = rau_pkg::MSEL_P0;
      case (state_ff)
         rau_pkg::ST_IDLE: begin
            if (start) begin
               dp_cmd.load = 1'b1;
               state_in = rau_pkg::ST_MUL0;
            end
         end
         rau_pkg::ST_MUL0: begin
            dp_cmd.mul_en = 1'b1;
            dp_cmd.mul_sel = rau_pkg::MSEL_P0;
            state_in = rau_pkg::ST_MUL1;
         end
         rau_pkg::ST_MUL1: begin
            dp_cmd.mul_en = 1'b1;
            dp_cmd.mul_sel = rau_pkg::MSEL_P1;
            state_in = rau_pkg::ST_MUL2;
         end
         rau_pkg::ST_MUL2: begin
            dp_cmd.mul_en = 1'b1;
            dp_cmd.mul_sel = rau_pkg::MSEL_P2;
            state_in = rau_pkg::ST_COMB;
         end
         rau_pkg::ST_COMB: begin
            dp_cmd.combine = 1'b1;
            state_in = dp_sts.reduce ? rau_pkg::ST_GCD : rau_pkg::ST_FIN;
         end
         rau_pkg::ST_GCD: begin
            if (dp_sts.gcd_done) begin
               if (dp_sts.gcd_zero) begin
                  state_in = rau_pkg::ST_FIN;
               end else begin
                  dp_cmd.div_init = 1'b1;
                  state_in = rau_pkg::ST_DIV;
               end
            end else begin
               dp_cmd.gcd_step = 1'b1;
            end
         end
         rau_pkg::ST_DIV: begin
            if (dp_sts.div_done) begin
               state_in = rau_pkg::ST_FIN;
            end else begin
               dp_cmd.div_step = 1'b1;
            end
         end
         rau_pkg::ST_FIN: begin
            dp_cmd.finish = 1'b1;
            state_in = rau_pkg::ST_IDLE;
         end
         default: begin
            state_in = rau_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != rau_pkg::ST_IDLE);

   `RAU_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted item did not raise busy")
   `RAU_ASSERT_NEXT(a_finish_idle, dp_cmd.finish, !busy, "block still busy after finishing an item")
   `RAU_ASSERT_IMP(a_div_after_gcd, dp_cmd.div_init, dp_sts.gcd_done && !dp_sts.gcd_zero, "division started without a nonzero gcd")

endmodule

/* rtl/rational_arithmetic_unit_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// integer commands pass through the multiply, combine and finish states;
// fraction commands also run binary gcd steps and, for a nonzero gcd, a restoring
// division of the NW-bit magnitudes, NW = 2*OPERAND_WIDTH+1 (capped at 64)
// one item at a time: busy stays high until the result strobe is issued
// results are strobed for one cycle, the receiver cannot stall
// reset (synchronous, active high) returns the controller to idle
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core #(
   parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   output logic                                   busy,
   input  logic [rau_pkg::CMD_WIDTH-1:0]          req_cmd,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_den,
   output logic                                   rsp_valid,
   output logic signed [rau_pkg::NUM_WIDTH-1:0]   rsp_res_num,
   output logic signed [rau_pkg::DEN_WIDTH-1:0]   rsp_res_den,
   output logic                                   rsp_is_proper,
   output logic                                   rsp_zero_gcd_error
);

   rau_pkg::rau_cmd_type dp_cmd;
   rau_pkg::rau_sts_type dp_sts;

   // controller
   rau_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .busy   (busy),
      .dp_cmd (dp_cmd),
      .dp_sts (dp_sts)
   );

   // datapath
   rau_dp #(
      .OPERAND_WIDTH(OPERAND_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .dp_cmd             (dp_cmd),
      .dp_sts             (dp_sts),
      .req_cmd            (req_cmd),
      .req_a_num          (req_a_num),
      .req_a_den          (req_a_den),
      .req_b_num          (req_b_num),
      .req_b_den          (req_b_den),
      .rsp_valid          (rsp_valid),
      .rsp_res_num        (rsp_res_num),
      .rsp_res_den        (rsp_res_den),
      .rsp_is_proper      (rsp_is_proper),
      .rsp_zero_gcd_error (rsp_zero_gcd_error)
   );

endmodule

/* sim/rational_arithmetic_unit_core_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_checker
// watches the command and result channels, works out the expected fraction
// for every accepted item and compares each strobed result against it
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_checker (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   start,
   input  logic                                   busy,
   input  logic [rau_pkg::CMD_WIDTH-1:0]          req_cmd,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_den,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_num,
   input  logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_den,
   input  logic                                   rsp_valid,
   input  logic [rau_pkg::NUM_WIDTH-1:0]          rsp_res_num,
   input  logic [rau_pkg::DEN_WIDTH-1:0]          rsp_res_den,
   input  logic                                   rsp_is_proper,
   input  logic                                   rsp_zero_gcd_error,
   output int                                     fail_count,
   output int                                     pending_count
);

   typedef struct packed {
      logic [rau_pkg::NUM_WIDTH-1:0] num;
      logic [rau_pkg::DEN_WIDTH-1:0] den;
      logic                          proper;
      logic                          zero_gcd;
   } fraction_result_type;

   fraction_result_type expected_fractions[$];

   function automatic longint unsigned magnitude(longint signed v);
      return (v < 0) ? longint'(-v) : longint'(v);
   endfunction

   function automatic longint unsigned euclid_gcd(longint unsigned x, longint unsigned y);
      longint unsigned r;
      while (y != 0) begin
         r = x % y;
         x = y;
         y = r;
      end
      return x;
   endfunction

   // exact fraction arithmetic with reduction for the fraction commands
   function automatic fraction_result_type compute_fraction(rau_pkg::rau_op_type op,
         logic signed [15:0] an16, logic signed [15:0] ad16,
         logic signed [15:0] bn16, logic signed [15:0] bd16);
      fraction_result_type r;
      longint signed an, ad, bn, bd, n, d;
      longint unsigned nm, dm, g;
      logic nneg, dneg;
      an = an16; ad = ad16; bn = bn16; bd = bd16;
      case (op)
         rau_pkg::OP_FADD: begin n = an*bd + bn*ad; d = ad*bd; end
         rau_pkg::OP_FSUB: begin n = an*bd - bn*ad; d = ad*bd; end
         rau_pkg::OP_FMUL: begin n = an*bn; d = ad*bd; end
         rau_pkg::OP_FDIV: begin n = an*bd; d = ad*bn; end
         rau_pkg::OP_IADD: begin n = an + bn*ad; d = ad; end
         rau_pkg::OP_ISUB: begin n = an - bn*ad; d = ad; end
         rau_pkg::OP_IMUL: begin n = an*bn; d = ad; end
         default: begin n = an; d = ad*bn; end
      endcase
      nm = magnitude(n);
      dm = magnitude(d);
      r.zero_gcd = 1'b0;
      if (op inside {rau_pkg::OP_FADD, rau_pkg::OP_FSUB, rau_pkg::OP_FMUL,
                     rau_pkg::OP_FDIV}) begin
         nneg = n < 0;
         dneg = d < 0;
         g = euclid_gcd(nm, dm);
         if (g == 0) begin
            r.zero_gcd = 1'b1;
            nneg = 1'b0;
            dneg = 1'b0;
         end else begin
            nm = nm / g;
            dm = dm / g;
         end
         if (dneg) nneg = !nneg;
         n = nneg ? -longint'(nm) : longint'(nm);
         d = longint'(dm);
      end
      r.num = n[rau_pkg::NUM_WIDTH-1:0];
      r.den = d[rau_pkg::DEN_WIDTH-1:0];
      r.proper = nm < dm;
      return r;
   endfunction

   assign pending_count = expected_fractions.size();

   // predict on accept, compare on strobe
   always @(posedge clock) begin
      fraction_result_type want;
      if (reset) begin
         fail_count <= 0;
      end else begin
         if (start && !busy)
            expected_fractions.push_back(compute_fraction(rau_pkg::rau_op_type'(req_cmd),
               req_a_num, req_a_den, req_b_num, req_b_den));
         if (rsp_valid) begin
            if (expected_fractions.size() == 0) begin
               $display("%0t: unexpected result num=%h den=%h", $time,
                  rsp_res_num, rsp_res_den);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_fractions.pop_front();
               if (want.num !== rsp_res_num || want.den !== rsp_res_den ||
                   want.proper !== rsp_is_proper || want.zero_gcd !== rsp_zero_gcd_error) begin
                  $display("%0t: mismatch expected num=%h den=%h proper=%b err=%b", $time,
                     want.num, want.den, want.proper, want.zero_gcd);
                  $display("%0t:            actual num=%h den=%h proper=%b err=%b", $time,
                     rsp_res_num, rsp_res_den, rsp_is_proper, rsp_zero_gcd_error);
                  fail_count <= fail_count + 1;
               end
            end
         end
      end
   end

endmodule

/* sim/rational_arithmetic_unit_core_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core_tb
// drives directed corner fractions and then random commands with gaps of
// varying density; the checker predicts and compares every result
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core_tb;

   localparam int CYCLE_LIMIT = 400000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [rau_pkg::CMD_WIDTH-1:0] req_cmd = '0;
   logic signed [rau_pkg::FIELD_WIDTH-1:0] req_a_num = '0, req_a_den = '0;
   logic signed [rau_pkg::FIELD_WIDTH-1:0] req_b_num = '0, req_b_den = '0;
   logic rsp_valid;
   logic signed [rau_pkg::NUM_WIDTH-1:0] rsp_res_num;
   logic signed [rau_pkg::DEN_WIDTH-1:0] rsp_res_den;
   logic rsp_is_proper, rsp_zero_gcd_error;
   int fail_count, pending_count;
   int cycle_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rational_arithmetic_unit_core dut (.*);

   rational_arithmetic_unit_core_checker checker_i (.*);

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // random operand, biased towards small values and corners
   function automatic logic [15:0] pick_operand();
      case ($urandom_range(0, 5))
         0: return 16'($signed($urandom_range(0, 18)) - 9);
         1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
         2: return 16'($signed($urandom_range(0, 200)) - 100);
         default: return 16'($urandom);
      endcase
   endfunction

   // present one item and hold it until the block takes it
   task automatic issue_item(rau_pkg::rau_op_type op, logic [15:0] an, logic [15:0] ad,
                             logic [15:0] bn, logic [15:0] bd, int idle_pct);
      while (idle_pct > 0 && $urandom_range(1, 100) <= idle_pct)
         @(posedge clock);
      start     <= 1'b1;
      req_cmd   <= op;
      req_a_num <= an;
      req_a_den <= ad;
      req_b_num <= bn;
      req_b_den <= bd;
      do @(posedge clock); while (busy);
      start <= 1'b0;
      // the block stays busy after an accept anyway
      @(posedge clock);
   endtask

   initial begin
      int idle_pct;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners: each operation, extremes, zero over zero, zero den
      for (int op = 0; op < 8; op++) begin
         issue_item(rau_pkg::rau_op_type'(op), 16'sd3, 16'sd4, -16'sd5, 16'sd6, 0);
         issue_item(rau_pkg::rau_op_type'(op), 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 0);
      end
      issue_item(rau_pkg::OP_FADD, 16'sd0, 16'sd0, 16'sd0, 16'sd0, 0);
      issue_item(rau_pkg::OP_FMUL, 16'sd0, 16'sd5, 16'sd7, 16'sd0, 0);
      issue_item(rau_pkg::OP_FDIV, 16'sd7, 16'sd3, 16'sd0, 16'sd2, 0);
      issue_item(rau_pkg::OP_FSUB, -16'sd9, 16'sd0, 16'sd4, 16'sd1, 0);
      issue_item(rau_pkg::OP_IDIV, 16'sd5, 16'sd0, 16'sd3, 16'sd1, 0);
      issue_item(rau_pkg::OP_IADD, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 0);
      issue_item(rau_pkg::OP_FADD, 16'sd1, 16'sd2, 16'sd1, 16'sd2, 0);

      // hold off until everything in flight has come back
      while (pending_count != 0) @(posedge clock);

      // random phases: none, sender gaps 50%, 50%, 23%
      for (int phase = 0; phase < 4; phase++) begin
         idle_pct = (phase == 0) ? 0 : (phase == 3) ? 23 : 50;
         for (int i = 0; i < 160; i++)
            issue_item(rau_pkg::rau_op_type'($urandom_range(0, 7)), pick_operand(),
               pick_operand(), pick_operand(), pick_operand(), idle_pct);
      end

      while (pending_count != 0) @(posedge clock);
      repeat (150) @(posedge clock);
      if (fail_count == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

/* rational_arithmetic_unit_core.f */
+incdir+rtl
rtl/rau_pkg.sv
rtl/rau_div.sv
rtl/rau_dp.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit_core.sv
sim/rational_arithmetic_unit_core_checker.sv
sim/rational_arithmetic_unit_core_tb.sv
